// ===== rtl/wss_pkg.sv =====
package wss_pkg;

    typedef enum logic
    {
        JOB_POINT   = 1'b0,
        JOB_SEGMENT = 1'b1
    } job_kind_t;

    // points carried by one job: P0..P3
    localparam int JOB_PTS = 4;

endpackage

// ===== rtl/waypoint_spline_smoother.sv =====
// Channel  Handshake     Fields                          Transaction
// input    push / full   point_x, point_z, last_point    push && !full
// result   pop / empty   out_x, out_z, last_out          pop && !empty
//
// The front takes one waypoint per cycle while the job queue has room; a flagged
// waypoint stays there until it has queued its one to three jobs, one job at a time.
// The output stage delivers one point per cycle while pop is high: three points for a
// curved segment, two for a straight one, so an interior waypoint yields two or three points.
// A job passes through the job queue and the back pipeline registers to reach the output stage.
// Reset clears the window count, the job queue and the pipeline valid bits.
// A stalled pop holds the back pipeline; the two-entry job queue then fills and full rises.
module waypoint_spline_smoother #(
    parameter int COORD_WIDTH     = 24,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic                          last_point,
    input  logic                          push,
    output logic                          full,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_z,
    output logic                          last_out,
    output logic                          empty,
    input  logic                          pop
);

    localparam int JOB_W = 2 * wss_pkg::JOB_PTS * COORD_WIDTH + 2;

    logic             job_push;
    logic [JOB_W-1:0] job_wr_data;
    logic             job_full;
    logic             job_pop;
    logic [JOB_W-1:0] job_rd_data;
    logic             job_empty;

    wss_front #(
        .W (COORD_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_x     (point_x),
        .in_z     (point_z),
        .in_last  (last_point),
        .in_push  (push),
        .in_full  (full),
        .job_push (job_push),
        .job_data (job_wr_data),
        .job_full (job_full)
    );

    wss_job_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_wr_data),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_rd_data),
        .empty   (job_empty)
    );

    wss_back #(
        .W (COORD_WIDTH),
        .F (COORD_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!job_empty),
        .job_data  (job_rd_data),
        .job_pop   (job_pop),
        .out_x     (out_x),
        .out_z     (out_z),
        .out_last  (last_out),
        .out_empty (empty),
        .out_pop   (pop)
    );

endmodule

// ===== rtl/wss_job_fifo.sv =====
module wss_job_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/wss_front.sv =====
module wss_front #(
    parameter int W = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [W-1:0]                    in_x,
    input  logic signed [W-1:0]                    in_z,
    input  logic                                   in_last,
    input  logic                                   in_push,
    output logic                                   in_full,
    output logic                                   job_push,
    output logic [2*wss_pkg::JOB_PTS*W+1:0]        job_data,
    input  logic                                   job_full
);

    localparam int NPTS     = wss_pkg::JOB_PTS;
    localparam int KIND_BIT = 2 * NPTS * W;
    localparam int LAST_BIT = KIND_BIT + 1;

    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_FULL = 2'd3;

    logic signed [W-1:0] win_x_reg [3];
    logic signed [W-1:0] win_z_reg [3];
    logic [1:0]          seen_reg;
    logic [1:0]          seen_next;
    logic                hold_vld_reg;
    logic                hold_vld_next;
    logic signed [W-1:0] hold_x_reg;
    logic signed [W-1:0] hold_z_reg;
    logic                hold_last_reg;
    logic [1:0]          step_reg;
    logic [1:0]          step_next;

    logic signed [W-1:0] jx [NPTS];
    logic signed [W-1:0] jz [NPTS];
    logic signed [W-1:0] p0x;
    logic signed [W-1:0] p0z;
    wss_pkg::job_kind_t  jkind;
    logic                jlast;
    logic                jvld;
    logic                step_final;
    logic                moved;
    logic                done;
    logic                accept;

    always_comb
    begin
        p0x = (seen_reg == SEEN_FULL) ? win_x_reg[0] : win_x_reg[1];
        p0z = (seen_reg == SEEN_FULL) ? win_z_reg[0] : win_z_reg[1];
        for (int i = 0; i < NPTS; i++)
        begin
            jx[i] = '0;
            jz[i] = '0;
        end
        jkind      = wss_pkg::JOB_POINT;
        jlast      = 1'b0;
        jvld       = 1'b0;
        step_final = 1'b1;
        if (!hold_last_reg)
        begin
            if (seen_reg[1])
            begin
                jvld  = 1'b1;
                jkind = wss_pkg::JOB_SEGMENT;
                jx[0] = p0x;          jz[0] = p0z;
                jx[1] = win_x_reg[1]; jz[1] = win_z_reg[1];
                jx[2] = win_x_reg[2]; jz[2] = win_z_reg[2];
                jx[3] = hold_x_reg;   jz[3] = hold_z_reg;
            end
        end
        else
        begin
            case (seen_reg)
                SEEN_NONE:
                begin
                    jvld  = 1'b1;
                    jx[1] = hold_x_reg;
                    jz[1] = hold_z_reg;
                    jlast = 1'b1;
                end
                SEEN_ONE:
                begin
                    jvld = 1'b1;
                    if (step_reg == 2'd0)
                    begin
                        jx[1]      = win_x_reg[2];
                        jz[1]      = win_z_reg[2];
                        step_final = 1'b0;
                    end
                    else
                    begin
                        jx[1] = hold_x_reg;
                        jz[1] = hold_z_reg;
                        jlast = 1'b1;
                    end
                end
                default:
                begin
                    jvld = 1'b1;
                    case (step_reg)
                        2'd0:
                        begin
                            jkind      = wss_pkg::JOB_SEGMENT;
                            jx[0] = p0x;          jz[0] = p0z;
                            jx[1] = win_x_reg[1]; jz[1] = win_z_reg[1];
                            jx[2] = win_x_reg[2]; jz[2] = win_z_reg[2];
                            jx[3] = hold_x_reg;   jz[3] = hold_z_reg;
                            step_final = 1'b0;
                        end
                        2'd1:
                        begin
                            jkind      = wss_pkg::JOB_SEGMENT;
                            jx[0] = win_x_reg[1]; jz[0] = win_z_reg[1];
                            jx[1] = win_x_reg[2]; jz[1] = win_z_reg[2];
                            jx[2] = hold_x_reg;   jz[2] = hold_z_reg;
                            jx[3] = hold_x_reg;   jz[3] = hold_z_reg;
                            step_final = 1'b0;
                        end
                        default:
                        begin
                            jx[1] = hold_x_reg;
                            jz[1] = hold_z_reg;
                            jlast = 1'b1;
                        end
                    endcase
                end
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < NPTS; i++)
        begin
            job_data[i*W +: W]          = jx[i];
            job_data[(NPTS+i)*W +: W]   = jz[i];
        end
        job_data[KIND_BIT] = jkind;
        job_data[LAST_BIT] = jlast;
    end

    assign job_push = hold_vld_reg && jvld;
    assign moved    = job_push && !job_full;
    assign done     = hold_vld_reg && step_final && (!jvld || !job_full);
    assign in_full  = hold_vld_reg && !done;
    assign accept   = in_push && !in_full;

    always_comb
    begin
        hold_vld_next = hold_vld_reg;
        step_next     = step_reg;
        seen_next     = seen_reg;
        if (done)
        begin
            hold_vld_next = 1'b0;
            if (hold_last_reg)
            begin
                seen_next = SEEN_NONE;
            end
            else if (seen_reg != SEEN_FULL)
            begin
                seen_next = seen_reg + 1'b1;
            end
        end
        else if (moved)
        begin
            step_next = step_reg + 1'b1;
        end
        if (accept)
        begin
            hold_vld_next = 1'b1;
            step_next     = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
            step_reg     <= 2'd0;
            seen_reg     <= SEEN_NONE;
        end
        else
        begin
            hold_vld_reg <= hold_vld_next;
            step_reg     <= step_next;
            seen_reg     <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_x_reg    <= in_x;
            hold_z_reg    <= in_z;
            hold_last_reg <= in_last;
        end
        if (done && !hold_last_reg)
        begin
            win_x_reg[0] <= win_x_reg[1];
            win_z_reg[0] <= win_z_reg[1];
            win_x_reg[1] <= win_x_reg[2];
            win_z_reg[1] <= win_z_reg[2];
            win_x_reg[2] <= hold_x_reg;
            win_z_reg[2] <= hold_z_reg;
        end
    end

endmodule

// ===== rtl/wss_back.sv =====
module wss_back #(
    parameter int W = 24,
    parameter int F = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            job_valid,
    input  logic [2*wss_pkg::JOB_PTS*W+1:0] job_data,
    output logic                            job_pop,
    output logic signed [W-1:0]             out_x,
    output logic signed [W-1:0]             out_z,
    output logic                            out_last,
    output logic                            out_empty,
    input  logic                            out_pop
);

    localparam int NPTS        = wss_pkg::JOB_PTS;
    localparam int KIND_BIT    = 2 * NPTS * W;
    localparam int LAST_BIT    = KIND_BIT + 1;
    localparam int NSTG        = 5;
    localparam int NLN         = 4;
    localparam int D_W         = W + 1;
    localparam int P_W         = 2 * W + 2;
    localparam int SH          = 2 * F;
    localparam int S_W         = W + 6;
    localparam int RECIP       = 9709;
    localparam int RECIP_SHIFT = 18;
    localparam int DIVISOR     = 27;
    localparam int ROUND_ADD   = 13;
    localparam int M_W         = S_W + $clog2(RECIP + 1);
    localparam int T_W         = M_W + 1;
    localparam int Q_W         = T_W - RECIP_SHIFT;
    localparam int R_W         = Q_W + 5;

    localparam logic signed [S_W-1:0] K2  = S_W'(2);
    localparam logic signed [S_W-1:0] K9  = S_W'(9);
    localparam logic signed [S_W-1:0] K21 = S_W'(21);
    localparam logic signed [P_W-1:0] POS_OFF = P_W'((2 ** SH) / 2);
    localparam logic signed [P_W-1:0] NEG_OFF = P_W'(((2 ** SH) - 1) / 2);
    localparam logic [S_W-1:0] ADD_POS  = S_W'(ROUND_ADD);
    localparam logic [S_W-1:0] ADD_NEG  = S_W'(ROUND_ADD + 1);
    localparam logic [M_W-1:0] RECIP_M  = M_W'(RECIP);
    localparam logic [R_W-1:0] DIV_R    = R_W'(DIVISOR);
    localparam logic [Q_W-1:0] Q_POS_LIM = {{(Q_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_NEG_LIM = Q_POS_LIM + 1'b1;

    // pass-through per stage
    logic                vld_reg  [NSTG];
    logic                kind_reg [NSTG];
    logic                last_reg [NSTG];
    logic signed [W-1:0] p1x_reg  [NSTG];
    logic signed [W-1:0] p1z_reg  [NSTG];
    logic signed [W-1:0] p2x_reg  [NSTG];
    logic signed [W-1:0] p2z_reg  [NSTG];

    logic signed [D_W-1:0] s1_dx_reg  [3];
    logic signed [D_W-1:0] s1_dz_reg  [3];
    logic signed [S_W-1:0] s1_sum_reg [NLN];
    logic signed [P_W-1:0] s2_prod_reg [NLN];
    logic [S_W-1:0]        s2_n_reg   [NLN];
    logic                  s2_neg_reg [NLN];
    logic                  s3_flat_reg;
    logic [M_W-1:0]        s3_m_reg   [NLN];
    logic [S_W-1:0]        s3_n_reg   [NLN];
    logic                  s3_neg_reg [NLN];
    logic                  s4_flat_reg;
    logic [Q_W-1:0]        s4_q0_reg  [NLN];
    logic [S_W-1:0]        s4_n_reg   [NLN];
    logic                  s4_neg_reg [NLN];
    logic                  s5_flat_reg;
    logic [Q_W-1:0]        s5_q0_reg  [NLN];
    logic                  s5_rge_reg [NLN];
    logic                  s5_neg_reg [NLN];

    logic signed [W-1:0] em_x_reg [3];
    logic signed [W-1:0] em_z_reg [3];
    logic                em_busy_reg;
    logic                em_busy_next;
    logic [1:0]          em_idx_reg;
    logic [1:0]          em_idx_next;
    logic [1:0]          em_lastidx_reg;
    logic                em_last_reg;

    logic signed [W-1:0]   px [NPTS];
    logic signed [W-1:0]   pz [NPTS];
    logic signed [S_W-1:0] ex [NPTS];
    logic signed [S_W-1:0] ez [NPTS];
    logic signed [D_W-1:0] dx [3];
    logic signed [D_W-1:0] dz [3];
    logic signed [S_W-1:0] sum [NLN];
    logic signed [P_W-1:0] mul_a [NLN];
    logic signed [P_W-1:0] mul_b [NLN];
    logic signed [P_W-1:0] prod [NLN];
    logic [S_W-1:0]        n_val [NLN];
    logic                  n_neg [NLN];
    logic signed [P_W-1:0] rnd [NLN];
    logic                  flat;
    logic [M_W-1:0]        m_val [NLN];
    logic [T_W-1:0]        t_val [NLN];
    logic [R_W-1:0]        diff [NLN];
    logic                  rge [NLN];
    logic [Q_W-1:0]        q_val [NLN];
    logic signed [W-1:0]   samp [NLN];
    logic                  adv;
    logic                  em_end;

    assign em_end  = (em_idx_reg == em_lastidx_reg);
    assign adv     = !em_busy_reg || (out_pop && em_end);
    assign job_pop = adv && job_valid;

    // stage 1: differences to P0 and weighted sums
    always_comb
    begin
        for (int i = 0; i < NPTS; i++)
        begin
            px[i] = job_data[i*W +: W];
            pz[i] = job_data[(NPTS+i)*W +: W];
            ex[i] = {{(S_W-W){px[i][W-1]}}, px[i]};
            ez[i] = {{(S_W-W){pz[i][W-1]}}, pz[i]};
        end
        for (int i = 0; i < 3; i++)
        begin
            dx[i] = {px[i+1][W-1], px[i+1]} - {px[0][W-1], px[0]};
            dz[i] = {pz[i+1][W-1], pz[i+1]} - {pz[0][W-1], pz[0]};
        end
        sum[0] = K21 * ex[1] + K9 * ex[2] - K2 * ex[0] - ex[3];
        sum[1] = K21 * ez[1] + K9 * ez[2] - K2 * ez[0] - ez[3];
        sum[2] = K9 * ex[1] + K21 * ex[2] - ex[0] - K2 * ex[3];
        sum[3] = K9 * ez[1] + K21 * ez[2] - ez[0] - K2 * ez[3];
    end

    // stage 2: cross products, magnitudes plus rounding bias
    always_comb
    begin
        mul_a[0] = {{(P_W-D_W){s1_dx_reg[0][D_W-1]}}, s1_dx_reg[0]};
        mul_b[0] = {{(P_W-D_W){s1_dz_reg[1][D_W-1]}}, s1_dz_reg[1]};
        mul_a[1] = {{(P_W-D_W){s1_dz_reg[0][D_W-1]}}, s1_dz_reg[0]};
        mul_b[1] = {{(P_W-D_W){s1_dx_reg[1][D_W-1]}}, s1_dx_reg[1]};
        mul_a[2] = {{(P_W-D_W){s1_dx_reg[0][D_W-1]}}, s1_dx_reg[0]};
        mul_b[2] = {{(P_W-D_W){s1_dz_reg[2][D_W-1]}}, s1_dz_reg[2]};
        mul_a[3] = {{(P_W-D_W){s1_dz_reg[0][D_W-1]}}, s1_dz_reg[0]};
        mul_b[3] = {{(P_W-D_W){s1_dx_reg[2][D_W-1]}}, s1_dx_reg[2]};
        for (int l = 0; l < NLN; l++)
        begin
            prod[l]  = mul_a[l] * mul_b[l];
            n_neg[l] = s1_sum_reg[l][S_W-1];
            n_val[l] = n_neg[l] ? (~s1_sum_reg[l] + ADD_NEG) : (s1_sum_reg[l] + ADD_POS);
        end
    end

    // stage 3: round products half away from zero, compare; scale by reciprocal
    always_comb
    begin
        for (int l = 0; l < NLN; l++)
        begin
            rnd[l]   = (s2_prod_reg[l] + (s2_prod_reg[l][P_W-1] ? NEG_OFF : POS_OFF)) >>> SH;
            m_val[l] = M_W'(s2_n_reg[l]) * RECIP_M;
        end
        flat = (rnd[0] == rnd[1]) && (rnd[2] == rnd[3]);
    end

    // stage 4: fold the repeating reciprocal
    always_comb
    begin
        for (int l = 0; l < NLN; l++)
        begin
            t_val[l] = T_W'(s3_m_reg[l]);
            for (int k = 1; k * RECIP_SHIFT < M_W; k++)
            begin
                t_val[l] = t_val[l] + T_W'(s3_m_reg[l] >> (k * RECIP_SHIFT));
            end
        end
    end

    // stage 5: quotient correction
    always_comb
    begin
        for (int l = 0; l < NLN; l++)
        begin
            diff[l] = R_W'(s4_n_reg[l]) - R_W'(s4_q0_reg[l]) * DIV_R;
            rge[l]  = (diff[l] >= DIV_R);
        end
    end

    // output load: apply sign, saturate
    always_comb
    begin
        for (int l = 0; l < NLN; l++)
        begin
            q_val[l] = s5_q0_reg[l] + Q_W'(s5_rge_reg[l]);
            if (!s5_neg_reg[l] && (q_val[l] > Q_POS_LIM))
            begin
                samp[l] = {1'b0, {(W-1){1'b1}}};
            end
            else if (s5_neg_reg[l] && (q_val[l] > Q_NEG_LIM))
            begin
                samp[l] = {1'b1, {(W-1){1'b0}}};
            end
            else if (s5_neg_reg[l])
            begin
                samp[l] = -q_val[l][W-1:0];
            end
            else
            begin
                samp[l] = q_val[l][W-1:0];
            end
        end
    end

    always_comb
    begin
        em_busy_next = em_busy_reg;
        em_idx_next  = em_idx_reg;
        if (adv)
        begin
            em_busy_next = vld_reg[NSTG-1];
            em_idx_next  = 2'd0;
        end
        else if (out_pop && em_busy_reg)
        begin
            em_idx_next = em_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            em_busy_reg <= 1'b0;
            em_idx_reg  <= 2'd0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg[0] <= job_valid;
                for (int s = 1; s < NSTG; s++)
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
            em_busy_reg <= em_busy_next;
            em_idx_reg  <= em_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg[0] <= job_data[KIND_BIT];
            last_reg[0] <= job_data[LAST_BIT];
            p1x_reg[0]  <= px[1];
            p1z_reg[0]  <= pz[1];
            p2x_reg[0]  <= px[2];
            p2z_reg[0]  <= pz[2];
            for (int s = 1; s < NSTG; s++)
            begin
                kind_reg[s] <= kind_reg[s-1];
                last_reg[s] <= last_reg[s-1];
                p1x_reg[s]  <= p1x_reg[s-1];
                p1z_reg[s]  <= p1z_reg[s-1];
                p2x_reg[s]  <= p2x_reg[s-1];
                p2z_reg[s]  <= p2z_reg[s-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                s1_dx_reg[i] <= dx[i];
                s1_dz_reg[i] <= dz[i];
            end
            for (int l = 0; l < NLN; l++)
            begin
                s1_sum_reg[l]  <= sum[l];
                s2_prod_reg[l] <= prod[l];
                s2_n_reg[l]    <= n_val[l];
                s2_neg_reg[l]  <= n_neg[l];
                s3_m_reg[l]    <= m_val[l];
                s3_n_reg[l]    <= s2_n_reg[l];
                s3_neg_reg[l]  <= s2_neg_reg[l];
                s4_q0_reg[l]   <= t_val[l][T_W-1:RECIP_SHIFT];
                s4_n_reg[l]    <= s3_n_reg[l];
                s4_neg_reg[l]  <= s3_neg_reg[l];
                s5_q0_reg[l]   <= s4_q0_reg[l];
                s5_rge_reg[l]  <= rge[l];
                s5_neg_reg[l]  <= s4_neg_reg[l];
            end
            s3_flat_reg <= flat;
            s4_flat_reg <= s3_flat_reg;
            s5_flat_reg <= s4_flat_reg;
        end
        if (adv && vld_reg[NSTG-1])
        begin
            em_x_reg[0] <= p1x_reg[NSTG-1];
            em_z_reg[0] <= p1z_reg[NSTG-1];
            em_x_reg[1] <= s5_flat_reg ? p2x_reg[NSTG-1] : samp[0];
            em_z_reg[1] <= s5_flat_reg ? p2z_reg[NSTG-1] : samp[1];
            em_x_reg[2] <= samp[2];
            em_z_reg[2] <= samp[3];
            em_last_reg <= last_reg[NSTG-1];
            if (kind_reg[NSTG-1] == wss_pkg::JOB_POINT)
            begin
                em_lastidx_reg <= 2'd0;
            end
            else if (s5_flat_reg)
            begin
                em_lastidx_reg <= 2'd1;
            end
            else
            begin
                em_lastidx_reg <= 2'd2;
            end
        end
    end

    assign out_x     = em_x_reg[em_idx_reg];
    assign out_z     = em_z_reg[em_idx_reg];
    assign out_last  = em_last_reg && em_end;
    assign out_empty = !em_busy_reg;

endmodule
